>>> rtl/lped_pkg.sv
// Shared types and constants for the length-prefixed entry deframer.
package lped_pkg;

	// Parse phases.
	localparam logic [2:0] PH_COUNT = 3'd0;
	localparam logic [2:0] PH_PLEN  = 3'd1;
	localparam logic [2:0] PH_PATH  = 3'd2;
	localparam logic [2:0] PH_DLEN  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_HALT  = 3'd5;

	// Status codes.
	localparam logic [2:0] ST_BUSY  = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_TRUNC = 3'd2;
	localparam logic [2:0] ST_COUNT = 3'd3;
	localparam logic [2:0] ST_PATH  = 3'd4;
	localparam logic [2:0] ST_DATA  = 3'd5;
	localparam logic [2:0] ST_TOTAL = 3'd6;

	// Byte roles.
	localparam logic [1:0] ROLE_HDR  = 2'd0;
	localparam logic [1:0] ROLE_PATH = 2'd1;
	localparam logic [1:0] ROLE_DATA = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAX_ENTRY = 2'd0;
	localparam logic [1:0] CFG_MAX_PATH  = 2'd1;
	localparam logic [1:0] CFG_MAX_DATA  = 2'd2;
	localparam logic [1:0] CFG_MAX_TOTAL = 2'd3;

	localparam int CFG_DATA_W = 36;

	// Limit values after reset.
	localparam logic [31:0] RST_MAX_ENTRY = 32'd200000;
	localparam logic [31:0] RST_MAX_PATH  = 32'd4096;
	localparam logic [31:0] RST_MAX_DATA  = 32'd33554432;
	localparam logic [35:0] RST_MAX_TOTAL = 36'd268435456;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  byte_role;
		logic [31:0] entry_index;
		logic        path_done;
		logic        entry_done;
		logic [2:0]  status;
	} result_t;

endpackage

>>> rtl/lped_front.sv
// Front end: accepts bytes, runs the framing parser and classifies each byte.
module lped_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     data_byte,
	input  logic                           stream_end,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [lped_pkg::CFG_DATA_W-1:0] cfg_data,
	output lped_pkg::result_t              result
);

	logic [31:0] max_entry_q, max_path_q, max_data_q;
	logic [35:0] max_total_q;

	logic [2:0]  phase_q, phase_n;
	logic [1:0]  pos_q, pos_n;
	logic [23:0] asm_q, asm_n;
	logic [31:0] left_q, left_n;
	logic [31:0] entries_q, entries_n;
	logic [31:0] entry_q, entry_n;
	logic [36:0] total_q, total_n;
	logic [2:0]  final_q, final_n;

	logic [31:0] len_v;
	logic [36:0] len_sum;
	logic        do_finish;

	assign len_v   = {data_byte, asm_q};
	assign len_sum = total_q + {5'd0, len_v};

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		asm_n     = asm_q;
		left_n    = left_q;
		entries_n = entries_q;
		entry_n   = entry_q;
		total_n   = total_q;
		final_n   = final_q;
		do_finish = 1'b0;

		result.out_byte    = data_byte;
		result.byte_role   = lped_pkg::ROLE_HDR;
		result.entry_index = '0;
		result.path_done   = 1'b0;
		result.entry_done  = 1'b0;
		result.status      = lped_pkg::ST_BUSY;

		case (phase_q)
			lped_pkg::PH_HALT: begin
				result.status = final_q;
			end
			lped_pkg::PH_PATH, lped_pkg::PH_DATA: begin
				result.entry_index = entry_q;
				result.byte_role   = (phase_q == lped_pkg::PH_PATH) ?
					lped_pkg::ROLE_PATH : lped_pkg::ROLE_DATA;
				left_n = left_q - 32'd1;
				if (left_q == 32'd1) begin
					if (phase_q == lped_pkg::PH_PATH) begin
						result.path_done = 1'b1;
						phase_n          = lped_pkg::PH_DLEN;
					end else begin
						result.entry_done = 1'b1;
						do_finish         = 1'b1;
					end
				end
			end
			lped_pkg::PH_COUNT, lped_pkg::PH_PLEN, lped_pkg::PH_DLEN: begin
				// The entry counter is still zero while the count header is parsed.
				result.entry_index = entry_q;
				pos_n = pos_q + 2'd1;
				case (pos_q)
					2'd0: asm_n[7:0]   = data_byte;
					2'd1: asm_n[15:8]  = data_byte;
					2'd2: asm_n[23:16] = data_byte;
					default: asm_n     = '0;
				endcase
				if (pos_q == 2'd3) begin
					if (phase_q == lped_pkg::PH_COUNT) begin
						if (len_v > max_entry_q) begin
							phase_n = lped_pkg::PH_HALT;
							final_n = lped_pkg::ST_COUNT;
							result.status = lped_pkg::ST_COUNT;
						end else begin
							entries_n = len_v;
							if (len_v == 32'd0) begin
								phase_n = lped_pkg::PH_HALT;
								final_n = lped_pkg::ST_DONE;
								result.status = lped_pkg::ST_DONE;
							end else begin
								phase_n = lped_pkg::PH_PLEN;
							end
						end
					end else if (phase_q == lped_pkg::PH_PLEN) begin
						if (len_v > max_path_q) begin
							phase_n = lped_pkg::PH_HALT;
							final_n = lped_pkg::ST_PATH;
							result.status = lped_pkg::ST_PATH;
						end else begin
							// The path length joins the running total now, so the data
							// length check needs only one more add.
							total_n = len_sum;
							if (len_v == 32'd0) begin
								result.path_done = 1'b1;
								phase_n = lped_pkg::PH_DLEN;
							end else begin
								left_n  = len_v;
								phase_n = lped_pkg::PH_PATH;
							end
						end
					end else begin
						if (len_v > max_data_q) begin
							phase_n = lped_pkg::PH_HALT;
							final_n = lped_pkg::ST_DATA;
							result.status = lped_pkg::ST_DATA;
						end else if (len_sum > {1'b0, max_total_q}) begin
							phase_n = lped_pkg::PH_HALT;
							final_n = lped_pkg::ST_TOTAL;
							result.status = lped_pkg::ST_TOTAL;
						end else begin
							total_n = len_sum;
							if (len_v == 32'd0) begin
								result.entry_done = 1'b1;
								do_finish = 1'b1;
							end else begin
								left_n  = len_v;
								phase_n = lped_pkg::PH_DATA;
							end
						end
					end
				end
			end
			default: begin
				phase_n = lped_pkg::PH_COUNT;
			end
		endcase

		if (do_finish) begin
			entry_n   = entry_q + 32'd1;
			entries_n = entries_q - 32'd1;
			if (entries_q == 32'd1) begin
				phase_n = lped_pkg::PH_HALT;
				final_n = lped_pkg::ST_DONE;
				result.status = lped_pkg::ST_DONE;
			end else begin
				phase_n = lped_pkg::PH_PLEN;
			end
		end

		// The flagged last byte closes the message and starts the next one clean.
		if (stream_end) begin
			if (phase_n != lped_pkg::PH_HALT) begin
				result.status = lped_pkg::ST_TRUNC;
			end
			phase_n   = lped_pkg::PH_COUNT;
			pos_n     = '0;
			asm_n     = '0;
			left_n    = '0;
			entries_n = '0;
			entry_n   = '0;
			total_n   = '0;
			final_n   = lped_pkg::ST_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lped_pkg::PH_COUNT;
			pos_q     <= '0;
			asm_q     <= '0;
			left_q    <= '0;
			entries_q <= '0;
			entry_q   <= '0;
			total_q   <= '0;
			final_q   <= lped_pkg::ST_BUSY;
		end else if (accept) begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			asm_q     <= asm_n;
			left_q    <= left_n;
			entries_q <= entries_n;
			entry_q   <= entry_n;
			total_q   <= total_n;
			final_q   <= final_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entry_q <= lped_pkg::RST_MAX_ENTRY;
			max_path_q  <= lped_pkg::RST_MAX_PATH;
			max_data_q  <= lped_pkg::RST_MAX_DATA;
			max_total_q <= lped_pkg::RST_MAX_TOTAL;
		end else if (cfg_we) begin
			case (cfg_index)
				lped_pkg::CFG_MAX_ENTRY: max_entry_q <= cfg_data[31:0];
				lped_pkg::CFG_MAX_PATH:  max_path_q  <= cfg_data[31:0];
				lped_pkg::CFG_MAX_DATA:  max_data_q  <= cfg_data[31:0];
				lped_pkg::CFG_MAX_TOTAL: max_total_q <= cfg_data[35:0];
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_halt_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lped_pkg::PH_HALT |-> final_q != lped_pkg::ST_BUSY)
		else $error("halted parser without a final status");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_end |=> phase_q == lped_pkg::PH_COUNT && pos_q == 2'd0)
		else $error("parser not cleared after the last byte");

	a_field_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == lped_pkg::PH_PATH || phase_q == lped_pkg::PH_DATA) |-> left_q != 32'd0)
		else $error("byte field entered with nothing left");
`endif

endmodule

>>> rtl/lped_queue.sv
// Back end: a short result queue that delivers tagged bytes to the output channel.
module lped_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lped_pkg::result_t push_data,
	output logic              not_full,
	output logic              out_valid,
	input  logic              out_ready,
	output lped_pkg::result_t out_data
);

	localparam int PTR_W = (lped_pkg::QUEUE_DEPTH > 1) ? $clog2(lped_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(lped_pkg::QUEUE_DEPTH + 1);

	lped_pkg::result_t slot_q [lped_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign not_full  = count_q != CNT_W'(lped_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = slot_q[rd_q];
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(lped_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(lped_pkg::QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!not_full |-> out_valid)
		else $error("full queue shows no result");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("transfer into the queue was not counted");
`endif

endmodule

>>> rtl/length_prefixed_entry_deframer.sv
// Top level of the length-prefixed entry deframer: parser front end and result queue.
// Takes one message byte per transfer and returns one tagged byte per transfer. The
// message is a little-endian 32-bit entry count, then per entry a 32-bit path length,
// the path bytes, a 32-bit data length and the data bytes. Limits from the four
// configuration registers are checked on the byte that completes each length field;
// a byte with stream_end set closes the message (truncated if parsing is unfinished)
// and restarts the parser. Each byte is parsed in the cycle it is accepted and its
// result is registered in the result queue, so the block sustains one byte per cycle
// while the queue is not full; a two-entry result queue keeps input accepted while a
// result waits, and input stalls only when that queue is full.
module length_prefixed_entry_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           stream_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	output logic [1:0]                     byte_role,
	output logic [31:0]                    entry_index,
	output logic                           path_done,
	output logic                           entry_done,
	output logic [2:0]                     status,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [lped_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic              accept;
	lped_pkg::result_t front_res;
	lped_pkg::result_t back_res;

	assign accept = in_valid && in_ready;

	lped_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.result     (front_res)
	);

	lped_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_res),
		.not_full  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (back_res)
	);

	assign out_byte    = back_res.out_byte;
	assign byte_role   = back_res.byte_role;
	assign entry_index = back_res.entry_index;
	assign path_done   = back_res.path_done;
	assign entry_done  = back_res.entry_done;
	assign status      = back_res.status;

endmodule
